// File: rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Overlapping (same-cycle) implication checked on every clock, muted in reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/i64sm_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the int64 stack machine executor.
// No dependencies.
package i64sm_pkg;
  localparam int STACK_ENTRIES = 256;
  localparam int SP_W = $clog2(STACK_ENTRIES);
  localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);

  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_PUSH = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_SUB  = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;
  localparam logic [2:0] OP_HALT = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_BADDEPTH  = 3'd4;
endpackage

// File: rtl/int64_stack_machine_executor_core.sv
`timescale 1ns / 1ps
// Stack machine executor (RPN evaluator) on 64-bit words.
// Channels: in_tdata = {immediate, mode}, in_tlast = end of program.
// Result on the last request of each program: out_tdata = {status, value}.
// Push, nop and halt pass through decode and finish; add and sub through
// decode, two stack reads through the single memory read port, write-back
// and finish. Mul adds a 64x4 shift-add step per cycle on the shared unit.
// Div uses the same shared unit as a one-bit restoring divider, with steps
// for operand magnitude before and result sign fix-up after.
// The next request is taken back in idle; a program's last request with an
// ok result adds a fetch of the bottom word before the result is offered.
// The input is not ready while one request is at work. The result sits in
// an output register; when the receiver stalls, the block holds it and
// takes no new request until it has left. Reset (rst_n low, synchronous)
// empties the stack, clears halt and error state and drops any pending
// result. The stack memory is not cleared: only written entries are read.
// Depends on i64sm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module int64_stack_machine_executor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [2:0] mode, [66:3] immediate, zero fill
  input  logic        in_tlast,   // end_of_program
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [63:0] value, [66:64] status, zero fill
);
  localparam int SP_W = i64sm_pkg::SP_W;
  localparam int DW   = i64sm_pkg::DEPTH_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RDL   = 4'd2;
  localparam logic [3:0] S_OPS   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_FIX   = 4'd6;
  localparam logic [3:0] S_WB    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [2:0]    op_r;
  logic [63:0]   imm_r;
  logic          last_r;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          halted_r, halted_nxt;
  logic [2:0]    err_r, err_nxt;
  logic          out_valid_r;
  logic          bottom_pending_r;
  logic [63:0]   out_value_r;
  logic [2:0]    out_status_r;
  logic [63:0]   l_r, r_r, acc_r, rem_r;
  logic [6:0]    cnt_r;
  logic          neg_r;

  // stack memory, one write and one registered read port
  logic [63:0]   mem [i64sm_pkg::STACK_ENTRIES];
  logic [63:0]   rd_q;
  logic [SP_W-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [63:0]   wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // shared unit: 64-bit add/subtract with carry out
  logic [63:0] ua, ub;
  logic        usub;
  logic [64:0] usum;
  assign usum = {1'b0, ua} + (usub ? {1'b0, ~ub} : {1'b0, ub}) + {64'd0, usub};

  logic [63:0] l_mag, r_mag;
  assign l_mag = l_r[63] ? (64'd0 - l_r) : l_r;
  assign r_mag = r_r[63] ? (64'd0 - r_r) : r_r;

  logic [63:0] mul_part;
  logic [63:0] div_trial;
  assign div_trial = {rem_r[62:0], l_r[63]};

  logic active;
  assign active = !halted_r && (err_r == i64sm_pkg::ST_OK);
  // hold off while a result is pending, including the bottom-word fetch
  assign in_tready = (state_r == S_IDLE) && !out_valid_r && !bottom_pending_r;

  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    halted_nxt = halted_r;
    err_nxt    = err_r;
    rd_addr    = depth_r[SP_W-1:0] - SP_W'(1);
    wr_en      = 1'b0;
    wr_addr    = depth_r[SP_W-1:0];
    wr_data    = imm_r;
    ua         = acc_r;
    ub         = 64'd0;
    usub       = 1'b0;
    mul_part   = 64'd0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_FIN;
        if (active) begin
          case (op_r)
            i64sm_pkg::OP_PUSH: begin
              if (depth_r >= DW'(i64sm_pkg::STACK_ENTRIES)) begin
                err_nxt = i64sm_pkg::ST_OVERFLOW;
              end else begin
                wr_en     = 1'b1;
                depth_nxt = depth_r + DW'(1);
              end
            end
            i64sm_pkg::OP_ADD, i64sm_pkg::OP_SUB, i64sm_pkg::OP_MUL,
            i64sm_pkg::OP_DIV: begin
              if (depth_r < DW'(2)) begin
                err_nxt = i64sm_pkg::ST_UNDERFLOW;
              end else begin
                state_nxt = S_RDL;
              end
            end
            i64sm_pkg::OP_HALT: halted_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      S_RDL: begin
        // right operand arrives now; fetch the left one
        rd_addr   = depth_r[SP_W-1:0] - SP_W'(2);
        state_nxt = S_OPS;
      end
      S_OPS: begin
        // r_r holds right, rd_q is left (latched into l_r)
        case (op_r)
          i64sm_pkg::OP_ADD, i64sm_pkg::OP_SUB: state_nxt = S_WB;
          i64sm_pkg::OP_MUL: state_nxt = S_MUL;
          default: begin
            if (r_r == 64'd0) begin
              err_nxt   = i64sm_pkg::ST_DIVZERO;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_MUL: begin
        // add l * one nibble of r, shifted into place
        mul_part = l_r * {60'd0, r_r[3:0]};
        ua = acc_r;
        ub = mul_part << {cnt_r[3:0], 2'b00};
        if (cnt_r == 7'd15) begin
          state_nxt = S_WB;
        end
      end
      S_DIV: begin
        ua   = div_trial;
        ub   = r_r;
        usub = 1'b1;
        if (cnt_r == 7'd64) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        case (op_r)
          i64sm_pkg::OP_ADD: begin ua = l_r; ub = r_r; end
          i64sm_pkg::OP_SUB: begin ua = l_r; ub = r_r; usub = 1'b1; end
          default: begin ua = acc_r; end
        endcase
        wr_en     = 1'b1;
        wr_addr   = depth_r[SP_W-1:0] - SP_W'(2);
        wr_data   = usum[63:0];
        depth_nxt = depth_r - DW'(1);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        rd_addr   = '0;
        state_nxt = S_IDLE;
        if (last_r) begin
          depth_nxt  = '0;
          halted_nxt = 1'b0;
          err_nxt    = i64sm_pkg::ST_OK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      depth_r          <= '0;
      halted_r         <= 1'b0;
      err_r            <= i64sm_pkg::ST_OK;
      out_valid_r      <= 1'b0;
      bottom_pending_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      depth_r  <= depth_nxt;
      halted_r <= halted_nxt;
      err_r    <= err_nxt;
      bottom_pending_r <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_FIN && last_r) begin
        // bottom word is read this cycle; value lands next cycle
        out_valid_r <= (err_r != i64sm_pkg::ST_OK) ||
                       (depth_r != DW'(1));
        bottom_pending_r <= (err_r == i64sm_pkg::ST_OK) &&
                            (depth_r == DW'(1));
      end
      if (bottom_pending_r) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tdata[2:0];
      imm_r  <= in_tdata[66:3];
      last_r <= in_tlast;
    end
    if (state_r == S_FIN && last_r) begin
      out_value_r <= 64'd0;
      if (err_r != i64sm_pkg::ST_OK) begin
        out_status_r <= err_r;
      end else if (depth_r != DW'(1)) begin
        out_status_r <= i64sm_pkg::ST_BADDEPTH;
      end else begin
        out_status_r <= i64sm_pkg::ST_OK;
      end
    end
    if (bottom_pending_r) begin
      out_value_r <= rd_q;
    end
    case (state_r)
      S_RDL: r_r <= rd_q;
      S_OPS: begin
        l_r   <= rd_q;
        acc_r <= 64'd0;
        rem_r <= 64'd0;
        cnt_r <= 7'd0;
        neg_r <= rd_q[63] ^ r_r[63];
      end
      S_MUL: begin
        acc_r <= usum[63:0];
        r_r   <= {4'd0, r_r[63:4]};
        cnt_r <= cnt_r + 7'd1;
      end
      S_DIV: begin
        if (cnt_r == 7'd0) begin
          // first step: swap in magnitudes, no quotient bit yet
          l_r   <= l_mag;
          r_r   <= r_mag;
          cnt_r <= 7'd1;
        end else begin
          if (usum[64]) begin
            rem_r <= usum[63:0];
          end else begin
            rem_r <= div_trial;
          end
          acc_r <= {acc_r[62:0], usum[64]};
          l_r   <= {l_r[62:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
        end
      end
      S_FIX: begin
        if (neg_r) begin
          acc_r <= 64'd0 - acc_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_status_r, out_value_r};

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, state_r == S_IDLE, "ready outside idle")
  `ASSERT_IMPL(a_depth_max, clk, rst_n, 1'b1,
    depth_r <= DW'(i64sm_pkg::STACK_ENTRIES), "stack depth beyond capacity")
  `ASSERT_NEXT(a_fin_clear, clk, rst_n, state_r == S_FIN && last_r,
    depth_r == '0 && !halted_r && err_r == i64sm_pkg::ST_OK, "state not cleared")
  `ASSERT_IMPL(a_wb_depth, clk, rst_n, state_r == S_WB, depth_r >= DW'(2),
    "write-back with short stack")
endmodule

// File: test/int64_stack_machine_executor_core_checker.sv
`timescale 1ns / 1ps
// Checker for the int64 stack machine executor: watches both channels,
// predicts each program result and compares it. Depends on i64sm_pkg.
module int64_stack_machine_executor_core_checker
  import i64sm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value;
  } prog_result_t;

  logic [63:0]        stack_mem [STACK_ENTRIES];
  int                 depth;
  bit                 halted;
  logic [2:0]         err;
  prog_result_t       result_q[$];

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  task automatic run_instr(input logic [2:0] op, input logic [63:0] imm);
    logic [63:0] l, r, res;
    case (op)
      OP_PUSH: begin
        if (depth >= STACK_ENTRIES) err = ST_OVERFLOW;
        else begin
          stack_mem[depth] = imm;
          depth++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (depth < 2) err = ST_UNDERFLOW;
        else begin
          r = stack_mem[depth-1];
          l = stack_mem[depth-2];
          if (op == OP_DIV && r == 0) err = ST_DIVZERO;
          else begin
            case (op)
              OP_ADD:  res = l + r;
              OP_SUB:  res = l - r;
              OP_MUL:  res = l * r;
              default: res = div_trunc(l, r);
            endcase
            depth--;
            stack_mem[depth-1] = res;
          end
        end
      end
      OP_HALT: halted = 1;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    prog_result_t want;
    if (!rst_n) begin
      depth = 0;
      halted = 0;
      err = ST_OK;
      result_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) report("unexpected result", out_tdata[63:0], 0);
        else begin
          want = result_q.pop_front();
          if (out_tdata[66:64] !== want.status)
            report("status", out_tdata[66:64], want.status);
          if (out_tdata[63:0] !== want.value) report("value", out_tdata[63:0], want.value);
          if (out_tdata[71:67] !== 5'd0) report("fill", out_tdata[71:67], 0);
        end
      end
      if (in_tvalid && in_tready) begin
        if (!halted && err == ST_OK) run_instr(in_tdata[2:0], in_tdata[66:3]);
        if (in_tlast) begin
          if (err != ST_OK) want = '{status: err, value: 64'd0};
          else if (depth != 1) want = '{status: ST_BADDEPTH, value: 64'd0};
          else want = '{status: ST_OK, value: stack_mem[0]};
          result_q.push_back(want);
          depth = 0;
          halted = 0;
          err = ST_OK;
        end
      end
    end
    pending_results = result_q.size();
  end

endmodule

// File: test/int64_stack_machine_executor_core_test.sv
`timescale 1ns / 1ps
// Top of the stack machine executor test: directed and random programs,
// random idling on both channels. Depends on i64sm_pkg and the checker.
module int64_stack_machine_executor_core_test;
  import i64sm_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic [71:0] in_tdata = '0;
  logic        in_tlast = 0;
  logic        out_tready = 0;
  logic        in_tready, out_tvalid;
  logic [71:0] out_tdata;
  int          fail_count, pending_results;
  longint      cycles = 0;
  bit          long_stall = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  int64_stack_machine_executor_core DUT (.*);

  int64_stack_machine_executor_core_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("int64_stack_machine_executor_core_test: errors");
      $finish;
    end
  end

  // Receiver: random wait per result, one long hold-off when asked.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (long_stall) begin
        out_tready <= 0;
        repeat (600) @(negedge clk);
        long_stall = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  bit burst_mode = 0;

  task automatic send_instr(input logic [2:0] op, input logic [63:0] imm, input bit last);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {5'd0, imm, op};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return -64'd1;
      3: return 64'd0;
      4: return 64'($urandom_range(0, 20));
      5: return 64'd0 - 64'($urandom_range(1, 20));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Well-formed program of random length; small chance of extra noise.
  task automatic send_program(input int ops);
    int d;
    logic [2:0] op;
    d = 0;
    for (int k = 0; k < ops; k++) begin
      if (d < 2 || $urandom_range(0, 2) == 0) op = OP_PUSH;
      else op = 3'($urandom_range(OP_ADD, OP_DIV));
      if ($urandom_range(0, 19) == 0) op = 3'($urandom_range(0, 7));
      send_instr(op, rand_word(), 0);
      if (op == OP_PUSH) d++;
      else if (op >= OP_ADD && op <= OP_DIV) d--;
    end
    while (d > 1 && $urandom_range(0, 9) != 0) begin
      send_instr(3'($urandom_range(OP_ADD, OP_DIV)), rand_word(), 0);
      d--;
    end
    send_instr(3'($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : OP_NOP),
               rand_word(), 1);
  endtask

  initial begin
    int sent;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // Directed programs.
    send_instr(OP_PUSH, 64'h8000_0000_0000_0000, 0);
    send_instr(OP_PUSH, -64'd1, 0);
    send_instr(OP_DIV, 0, 1);                  // most negative over minus one
    send_instr(OP_PUSH, 64'h7fff_ffff_ffff_ffff, 0);
    send_instr(OP_PUSH, 64'd1, 0);
    send_instr(OP_ADD, 0, 1);                  // wrap on add
    send_instr(OP_PUSH, 64'd5, 0);
    send_instr(OP_PUSH, 64'd0, 0);
    send_instr(OP_DIV, 0, 0);                  // divide by zero
    send_instr(OP_PUSH, 64'd1, 1);             // ignored after error
    send_instr(OP_ADD, 0, 1);                  // underflow on last item
    send_instr(OP_PUSH, -64'd7, 0);
    send_instr(OP_PUSH, 64'd2, 0);
    send_instr(OP_SUB, 0, 0);
    send_instr(3'd7, 0, 0);                    // undefined opcode acts as nop
    send_instr(OP_PUSH, 64'd3, 0);
    send_instr(OP_MUL, 0, 0);
    send_instr(OP_HALT, 0, 0);
    send_instr(OP_PUSH, 64'd9, 1);             // ignored after halt
    send_instr(OP_PUSH, 64'd1, 0);
    send_instr(OP_HALT, 0, 1);                 // halt on last item
    send_instr(OP_NOP, 0, 1);                  // empty stack: bad depth
    send_instr(OP_PUSH, 64'd1, 0);
    send_instr(OP_PUSH, 64'd2, 1);             // two left: bad depth
    // Fill the stack to overflow, quickly.
    burst_mode = 1;
    for (int k = 0; k < STACK_ENTRIES + 1; k++) send_instr(OP_PUSH, k, 0);
    send_instr(OP_NOP, 0, 1);
    burst_mode = 0;
    // Pause until every result has come.
    while (pending_results != 0) @(posedge clk);
    // Long receiver hold-off while the sender keeps offering.
    long_stall = 1;
    burst_mode = 1;
    repeat (8) send_program($urandom_range(1, 4));
    burst_mode = 0;
    sent = 0;
    while (sent < 2000) begin
      int n;
      n = $urandom_range(0, 12);
      if ($urandom_range(0, 15) == 0) burst_mode = 1;
      send_program(n);
      burst_mode = 0;
      sent += n + 2;
    end
    while (pending_results != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("int64_stack_machine_executor_core_test: clean");
    else $display("int64_stack_machine_executor_core_test: errors");
    $finish;
  end

endmodule
